// ----- src/clas_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helpers of the command line argument splitter.
// Depends on nothing; every other file of the block but clas_if uses it.
package clas_pkg;

  localparam int BYTE_W = 8;
  localparam int ARG_W  = 8;
  localparam int BS_W   = 6;

  localparam int MAX_BACKSLASH_RUN_DEF = 32;
  localparam int MAX_ARGS_DEF          = 256;

  // Results beyond this count for one transaction are dropped.
  localparam int RESULT_LIMIT = 35;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;

  typedef struct packed {
    logic              bad;
    logic [BS_W-1:0]   nbs;
    logic              has_char;
    logic [BYTE_W-1:0] ch;
    logic              arg_close;
    logic [ARG_W-1:0]  arg;
  } cmd_t;

  function automatic logic is_blank(input logic [BYTE_W-1:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

endpackage

// ----- src/clas_if.sv -----
`timescale 1ns / 1ps
// Handshake interfaces of the splitter: the byte input channel and the result channel.
// Depends on nothing.
interface clas_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] cmd_byte;
  logic       last;
  logic       empty_line;

  modport source(output valid, cmd_byte, last, empty_line, input ready);
  modport sink(input valid, cmd_byte, last, empty_line, output ready);
endinterface

interface clas_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       char_valid;
  logic [7:0] arg_index;
  logic       arg_end;
  logic       run_last;
  logic       bad_input;

  modport source(output valid, out_char, char_valid, arg_index, arg_end, run_last, bad_input,
                 input ready);
  modport sink(input valid, out_char, char_valid, arg_index, arg_end, run_last, bad_input,
               output ready);
endinterface

// ----- src/clas_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts command line bytes, tracks the parsing state and turns each byte
// into one command for the back end. Depends on clas_pkg and clas_if.
module clas_front #(
  parameter int MAX_BACKSLASH_RUN = clas_pkg::MAX_BACKSLASH_RUN_DEF,
  parameter int MAX_ARGS          = clas_pkg::MAX_ARGS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  clas_in_if.sink         in_ch,
  input  logic            q_ready,
  output logic            push,
  output clas_pkg::cmd_t  cmd
);

  localparam logic [2:0] PH_START  = 3'd0;
  localparam logic [2:0] PH_PATH_Q = 3'd1;
  localparam logic [2:0] PH_PATH_U = 3'd2;
  localparam logic [2:0] PH_GAP    = 3'd3;
  localparam logic [2:0] PH_ARG    = 3'd4;

  localparam logic [clas_pkg::BS_W-1:0]  BS_MAX  = clas_pkg::BS_W'(MAX_BACKSLASH_RUN);
  localparam logic [clas_pkg::ARG_W-1:0] ARG_MAX = clas_pkg::ARG_W'(MAX_ARGS - 1);
  localparam logic [clas_pkg::BS_W:0]    LIMIT   = (clas_pkg::BS_W + 1)'(clas_pkg::RESULT_LIMIT);

  logic [2:0]                  phase_r, phase_nxt;
  logic [1:0]                  qc_r, qc_nxt;
  logic [clas_pkg::BS_W-1:0]   pb_r, pb_nxt;
  logic                        iqr_r, iqr_nxt;
  logic [clas_pkg::ARG_W-1:0]  ca_r, ca_nxt;

  logic [clas_pkg::BYTE_W-1:0] c;
  logic                        blank;
  logic                        consumed;
  logic [clas_pkg::BS_W:0]     nbs;
  logic                        has_char;
  logic [clas_pkg::BYTE_W-1:0] ch;
  logic                        arg_close;
  logic                        bad;

  assign in_ch.ready = q_ready;
  assign push        = in_ch.valid && q_ready;
  assign c           = in_ch.cmd_byte;
  assign blank       = clas_pkg::is_blank(c);

  always_comb begin
    phase_nxt = phase_r;
    qc_nxt    = qc_r;
    pb_nxt    = pb_r;
    iqr_nxt   = iqr_r;
    ca_nxt    = ca_r;
    consumed  = 1'b0;
    nbs       = '0;
    has_char  = 1'b0;
    ch        = '0;
    arg_close = 1'b0;
    bad       = 1'b0;
    if (in_ch.empty_line) begin
      phase_nxt = PH_START;
      qc_nxt    = '0;
      pb_nxt    = '0;
      iqr_nxt   = 1'b0;
      ca_nxt    = '0;
      bad       = 1'b1;
    end else begin
      if (phase_nxt == PH_START) begin
        if (c == clas_pkg::CH_QUOTE) begin
          phase_nxt = PH_PATH_Q;
          consumed  = 1'b1;
        end else begin
          phase_nxt = PH_PATH_U;
        end
      end
      if (!consumed) begin
        if (phase_nxt == PH_PATH_Q) begin
          if (c == clas_pkg::CH_QUOTE) begin
            arg_close = 1'b1;
            phase_nxt = PH_GAP;
          end else begin
            has_char = 1'b1;
            ch       = c;
          end
        end else if (phase_nxt == PH_PATH_U) begin
          if (blank) begin
            arg_close = 1'b1;
            phase_nxt = PH_GAP;
          end else begin
            has_char = 1'b1;
            ch       = c;
          end
        end else begin
          if (phase_nxt == PH_GAP && !blank) begin
            if (ca_nxt < ARG_MAX) begin
              ca_nxt = ca_nxt + 1'b1;
            end
            phase_nxt = PH_ARG;
            qc_nxt    = '0;
            pb_nxt    = '0;
            iqr_nxt   = 1'b0;
          end
          if (phase_nxt == PH_ARG) begin
            if (c == clas_pkg::CH_QUOTE) begin
              if (iqr_nxt) begin
                qc_nxt = qc_nxt + 1'b1;
                if (qc_nxt == 2'd3) begin
                  has_char = 1'b1;
                  ch       = clas_pkg::CH_QUOTE;
                  qc_nxt   = '0;
                end
              end else begin
                nbs = {2'b00, pb_nxt[clas_pkg::BS_W-1:1]};
                if (!pb_nxt[0]) begin
                  qc_nxt = qc_nxt + 1'b1;
                end else begin
                  has_char = 1'b1;
                  ch       = clas_pkg::CH_QUOTE;
                end
                pb_nxt  = '0;
                iqr_nxt = 1'b1;
              end
            end else begin
              if (iqr_nxt) begin
                iqr_nxt = 1'b0;
                if (qc_nxt == 2'd2) begin
                  qc_nxt = '0;
                end
              end
              if (c == clas_pkg::CH_BSLASH) begin
                if (pb_nxt < BS_MAX) begin
                  pb_nxt = pb_nxt + 1'b1;
                end
              end else if (blank && qc_nxt == 2'd0) begin
                nbs       = {1'b0, pb_nxt};
                pb_nxt    = '0;
                arg_close = 1'b1;
                phase_nxt = PH_GAP;
              end else begin
                nbs      = {1'b0, pb_nxt};
                pb_nxt   = '0;
                has_char = 1'b1;
                ch       = c;
              end
            end
          end
        end
      end
      if (in_ch.last) begin
        if (phase_nxt == PH_ARG) begin
          nbs       = nbs + {1'b0, pb_nxt};
          arg_close = 1'b1;
        end else if (phase_nxt == PH_PATH_Q || phase_nxt == PH_PATH_U) begin
          arg_close = 1'b1;
        end
        phase_nxt = PH_START;
        qc_nxt    = '0;
        pb_nxt    = '0;
        iqr_nxt   = 1'b0;
        ca_nxt    = '0;
      end
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.bad       = bad;
    cmd.ch        = ch;
    cmd.arg_close = arg_close;
    cmd.arg       = bad ? '0 : ca_r;
    if (!bad && ca_r != ca_nxt && !in_ch.last) begin
      cmd.arg = ca_nxt;
    end else if (!bad && phase_r == PH_GAP && !blank && !in_ch.last) begin
      cmd.arg = ca_nxt;
    end else if (!bad && phase_r == PH_GAP && !blank && in_ch.last) begin
      cmd.arg = (ca_r < ARG_MAX) ? ca_r + 1'b1 : ca_r;
    end
    if (nbs >= LIMIT) begin
      cmd.nbs      = LIMIT[clas_pkg::BS_W-1:0];
      cmd.has_char = 1'b0;
    end else begin
      cmd.nbs      = nbs[clas_pkg::BS_W-1:0];
      cmd.has_char = has_char;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      qc_r    <= '0;
      pb_r    <= '0;
      iqr_r   <= 1'b0;
      ca_r    <= '0;
    end else if (push) begin
      phase_r <= phase_nxt;
      qc_r    <= qc_nxt;
      pb_r    <= pb_nxt;
      iqr_r   <= iqr_nxt;
      ca_r    <= ca_nxt;
    end
  end

endmodule

// ----- src/clas_queue.sv -----
`timescale 1ns / 1ps
// Short command queue between the front end and the back end.
// Depends on clas_pkg.
module clas_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  clas_pkg::cmd_t  push_cmd,
  output logic            q_ready,
  input  logic            pop,
  output logic            q_valid,
  output clas_pkg::cmd_t  head
);

  localparam int DEPTH = clas_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  clas_pkg::cmd_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign q_ready = (count_r != CNT_FULL);
  assign q_valid = (count_r != '0);
  assign head    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ----- src/clas_back.sv -----
`timescale 1ns / 1ps
// Back end: expands each queued command into its result transactions, one per cycle
// while out_ch is ready, into the output register. Depends on clas_pkg and clas_if.
module clas_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  clas_pkg::cmd_t  head,
  output logic            pop,
  clas_out_if.source      out_ch
);

  logic [clas_pkg::BS_W-1:0]   cnt_r;
  logic [clas_pkg::BS_W-1:0]   total;
  logic [clas_pkg::BS_W-1:0]   nres;
  logic                        adv;
  logic                        final_res;
  logic                        out_valid_r;
  logic [clas_pkg::BYTE_W-1:0] out_char_r;
  logic                        char_valid_r;
  logic [clas_pkg::ARG_W-1:0]  arg_index_r;
  logic                        arg_end_r;
  logic                        run_last_r;
  logic                        bad_input_r;

  assign total = head.nbs + clas_pkg::BS_W'(head.has_char);

  always_comb begin
    if (head.bad) begin
      nres = clas_pkg::BS_W'(1);
    end else if (total != '0) begin
      nres = total;
    end else begin
      nres = clas_pkg::BS_W'(head.arg_close);
    end
  end

  assign adv       = !out_valid_r || out_ch.ready;
  assign final_res = (cnt_r == nres - 1'b1);
  assign pop       = q_valid && adv && (nres == '0 || final_res);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= q_valid && (nres != '0);
      if (q_valid) begin
        cnt_r <= pop ? '0 : cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && q_valid) begin
      bad_input_r <= head.bad;
      run_last_r  <= final_res;
      arg_index_r <= head.arg;
      arg_end_r   <= !head.bad && head.arg_close && final_res;
      if (head.bad || total == '0) begin
        out_char_r   <= '0;
        char_valid_r <= 1'b0;
      end else if (cnt_r < head.nbs) begin
        out_char_r   <= clas_pkg::CH_BSLASH;
        char_valid_r <= 1'b1;
      end else begin
        out_char_r   <= head.ch;
        char_valid_r <= 1'b1;
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_char   = out_char_r;
  assign out_ch.char_valid = char_valid_r;
  assign out_ch.arg_index  = arg_index_r;
  assign out_ch.arg_end    = arg_end_r;
  assign out_ch.run_last   = run_last_r;
  assign out_ch.bad_input  = bad_input_r;

endmodule

// ----- src/command_line_argument_splitter.sv -----
`timescale 1ns / 1ps
// Command line argument splitter. The input channel takes one command line byte per
// transaction with last marking the final byte and empty_line flagging an empty line.
// The result channel gives the characters of the split arguments, each with its argument
// number; arg_end marks where an argument closes and run_last the final result of one
// input transaction. An empty line gives one result with bad_input set.
// A byte is classified by the front end in the cycle it is accepted and goes into a
// two-entry command queue; the back end writes one result per cycle into the output
// register while the receiver takes them, so the first result of a byte passes through
// the queue and then the output register before it can be taken.
// Ordinary text streams at one byte per cycle while the output is taken. A byte that
// releases k held backslashes plus a character yields k + 1 results, and a byte with no
// result still passes through the back end; the input stalls once the queue is full.
// Reset returns the parser to the start of a program path and empties the queue and the
// output register. When the receiver stalls, the output register holds its result, the
// queue fills, and then ready drops on the input channel.
// Depends on clas_pkg, clas_if, clas_front, clas_queue and clas_back.
module command_line_argument_splitter #(
  parameter int MAX_BACKSLASH_RUN = clas_pkg::MAX_BACKSLASH_RUN_DEF,
  parameter int MAX_ARGS          = clas_pkg::MAX_ARGS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  clas_in_if.sink     in_ch,
  clas_out_if.source  out_ch
);

  clas_pkg::cmd_t push_cmd;
  clas_pkg::cmd_t head;
  logic           push;
  logic           pop;
  logic           q_ready;
  logic           q_valid;

  clas_front #(
    .MAX_BACKSLASH_RUN(MAX_BACKSLASH_RUN),
    .MAX_ARGS(MAX_ARGS)
  ) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .q_ready(q_ready),
    .push(push),
    .cmd(push_cmd)
  );

  clas_queue u_queue (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .push_cmd(push_cmd),
    .q_ready(q_ready),
    .pop(pop),
    .q_valid(q_valid),
    .head(head)
  );

  clas_back u_back (
    .clk(clk),
    .rst_n(rst_n),
    .q_valid(q_valid),
    .head(head),
    .pop(pop),
    .out_ch(out_ch)
  );

endmodule
